// ===== sv/wtre_pkg.sv =====
// shared constants, types and ring arithmetic for the transfer rate estimator
package wtre_pkg;

    localparam int WINDOW_SECONDS = 30;
    localparam int SAMPLE_DEPTH   = 64;
    localparam int MS_PER_S       = 1000;

    localparam int IDX_W     = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W     = $clog2(SAMPLE_DEPTH + 1);
    localparam int TIME_W    = 48;
    localparam int BYTES_W   = 48;
    localparam int RATE_W    = 59;
    localparam int MAG_W     = RATE_W - 1;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);

    localparam int S_TDATA_W = TIME_W + BYTES_W;
    localparam int M_TDATA_W = ((RATE_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(WINDOW_SECONDS * MS_PER_S);

    // request kinds carried on s_tuser
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [BYTES_W-1:0] bytes;
    } sample_t;

    typedef struct packed {
        logic              start;
        logic              negative;
        logic [MAG_W-1:0]  magnitude;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    // base + offset modulo the ring depth, both operands below the depth
    function automatic idx_t ring_add(idx_t base, cnt_t offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= (CNT_W + 1)'(SAMPLE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(SAMPLE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/wtre_ring.sv =====
// sample ring memory, one write and one registered read port
module wtre_ring (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  wtre_pkg::idx_t    wr_addr,
    input  wtre_pkg::sample_t wr_data,
    input  logic              rd_en,
    input  wtre_pkg::idx_t    rd_addr,
    output wtre_pkg::sample_t rd_data
);

    wtre_pkg::sample_t ring_mem [wtre_pkg::SAMPLE_DEPTH];
    wtre_pkg::sample_t rd_raw_reg;
    logic              zero_ok_reg;
    logic              rd_blank_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= ring_mem[rd_addr];
        end
    end

    // entry zero reads as the zero sample until written after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_ok_reg  <= 1'b0;
            rd_blank_reg <= 1'b0;
        end else begin
            if (wr_en && wr_addr == '0) begin
                zero_ok_reg <= 1'b1;
            end
            if (rd_en) begin
                rd_blank_reg <= (rd_addr == '0) && !zero_ok_reg;
            end
        end
    end

    assign rd_data = rd_blank_reg ? '0 : rd_raw_reg;

endmodule

// ===== sv/wtre_div.sv =====
// restoring divider, one quotient bit per cycle, sign applied at the end
module wtre_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wtre_pkg::div_req_t                req,
    output logic                              done,
    output logic signed [wtre_pkg::RATE_W-1:0] quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [wtre_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [wtre_pkg::TIME_W-1:0]        rem_reg;
    logic [wtre_pkg::TIME_W-1:0]        rem_next;
    logic [wtre_pkg::MAG_W-1:0]         quo_reg;
    logic [wtre_pkg::MAG_W-1:0]         quo_next;
    logic [wtre_pkg::TIME_W-1:0]        dvs_reg;
    logic                               neg_reg;
    logic [wtre_pkg::TIME_W:0]          shifted;
    logic [wtre_pkg::TIME_W+1:0]        diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[wtre_pkg::MAG_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        if (diff[wtre_pkg::TIME_W+1]) begin
            rem_next = shifted[wtre_pkg::TIME_W-1:0];
            quo_next = {quo_reg[wtre_pkg::MAG_W-2:0], 1'b0};
        end else begin
            rem_next = diff[wtre_pkg::TIME_W-1:0];
            quo_next = {quo_reg[wtre_pkg::MAG_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == wtre_pkg::DIV_CNT_W'(wtre_pkg::MAG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.magnitude;
            dvs_reg <= req.divisor;
            neg_reg <= req.negative;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== sv/windowed_transfer_rate_estimator.sv =====
// top level: request sequencer around the sample ring and the rate divider
//
//  channel | ports              | tdata / tuser
//  s_      | s_tvalid, s_tready | tdata: current_tick [47:0], actual_bytes [95:48];
//          |                    | tuser: mode (0 tick, 1 transfer start)
//  m_      | m_tvalid, m_tready | tdata: average_rate [58:0], zero fill [63:59]
//
// a tick request passes the ring read of the newest sample, the write-back, the read of the
// oldest sample and the multiply, then starts the bit-serial divider and latches the quotient
// before it is presented
// a start request goes to ST_OUT without a division, and its result repeats the last average
// one request is in work at a time; the next is taken while a result waits on m_
// aresetn is synchronous; reset leaves one zero sample in the ring
module windowed_transfer_rate_estimator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wtre_pkg::S_TDATA_W-1:0]     s_tdata,  // current_tick, actual_bytes
    input  logic                               s_tuser,  // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wtre_pkg::M_TDATA_W-1:0]     m_tdata   // average_rate
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CMP      = 7'b0000010,
        ST_RD_OLD   = 7'b0000100,
        ST_MUL      = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t                                 state_reg, state_next;
    wtre_pkg::idx_t                         oldest_reg, oldest_next;
    wtre_pkg::cnt_t                         count_reg, count_next;
    logic [wtre_pkg::TIME_W-1:0]            now_reg, now_next;
    logic [wtre_pkg::BYTES_W-1:0]           actual_reg, actual_next;
    logic signed [wtre_pkg::RATE_W-1:0]     hold_reg, hold_next;
    logic signed [wtre_pkg::RATE_W-1:0]     num_reg, num_next;
    logic [wtre_pkg::TIME_W-1:0]            elapsed_reg, elapsed_next;
    logic                                   m_valid_reg, m_valid_next;
    logic signed [wtre_pkg::RATE_W-1:0]     m_data_reg, m_data_next;

    logic                                   wr_en;
    wtre_pkg::idx_t                         wr_addr;
    wtre_pkg::sample_t                      wr_data;
    logic                                   rd_en;
    wtre_pkg::idx_t                         rd_addr;
    wtre_pkg::sample_t                      rd_data;

    wtre_pkg::div_req_t                     div_req;
    logic                                   div_done;
    logic signed [wtre_pkg::RATE_W-1:0]     div_quot;

    logic                                   full;
    wtre_pkg::idx_t                         newest;
    wtre_pkg::idx_t                         push_pos;
    wtre_pkg::idx_t                         push_oldest;
    wtre_pkg::cnt_t                         push_count;
    logic [wtre_pkg::TIME_W-1:0]            elapsed;
    logic signed [wtre_pkg::BYTES_W:0]      delta;
    logic signed [wtre_pkg::RATE_W-1:0]     delta_ext;
    logic signed [wtre_pkg::RATE_W-1:0]     neg_num;
    logic                                   s_accept;

    wtre_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wtre_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // append position: overwrite the oldest sample once the ring is full
    always_comb begin
        full        = (count_reg == wtre_pkg::CNT_W'(wtre_pkg::SAMPLE_DEPTH));
        newest      = wtre_pkg::ring_add(oldest_reg, count_reg - 1'b1);
        push_pos    = full ? oldest_reg : wtre_pkg::ring_add(oldest_reg, count_reg);
        push_oldest = full ? wtre_pkg::ring_add(oldest_reg, wtre_pkg::CNT_W'(1)) : oldest_reg;
        push_count  = full ? count_reg : count_reg + 1'b1;
    end

    always_comb begin
        elapsed   = now_reg - rd_data.stamp;
        delta     = $signed({1'b0, actual_reg}) - $signed({1'b0, rd_data.bytes});
        delta_ext = {{(wtre_pkg::RATE_W - wtre_pkg::BYTES_W - 1){delta[wtre_pkg::BYTES_W]}},
                     delta};
        neg_num   = -num_reg;
    end

    always_comb begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        actual_next  = actual_reg;
        hold_next    = hold_reg;
        num_next     = num_reg;
        elapsed_next = elapsed_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = push_pos;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = newest;

        div_req.start     = 1'b0;
        div_req.negative  = num_reg[wtre_pkg::RATE_W-1];
        div_req.magnitude = num_reg[wtre_pkg::RATE_W-1] ? neg_num[wtre_pkg::MAG_W-1:0]
                                                        : num_reg[wtre_pkg::MAG_W-1:0];
        div_req.divisor   = elapsed_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    now_next    = s_tdata[wtre_pkg::TIME_W-1:0];
                    actual_next = s_tdata[wtre_pkg::S_TDATA_W-1:wtre_pkg::TIME_W];
                    if (s_tuser == wtre_pkg::MODE_START) begin
                        // transfer start: append (time, 0)
                        wr_en         = 1'b1;
                        wr_data.stamp = s_tdata[wtre_pkg::TIME_W-1:0];
                        wr_data.bytes = '0;
                        oldest_next   = push_oldest;
                        count_next    = push_count;
                        state_next    = ST_OUT;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                wr_en = 1'b1;
                if (actual_reg != '0 && rd_data.bytes == actual_reg) begin
                    // unchanged count: only move the newest sample forward in time
                    wr_addr       = newest;
                    wr_data.stamp = now_reg;
                    wr_data.bytes = rd_data.bytes;
                end else begin
                    wr_data.stamp = now_reg;
                    wr_data.bytes = actual_reg;
                    oldest_next   = push_oldest;
                    count_next    = push_count;
                end
                state_next = ST_RD_OLD;
            end
            ST_RD_OLD: begin
                rd_en      = 1'b1;
                rd_addr    = oldest_reg;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                num_next     = delta_ext * $signed(wtre_pkg::RATE_W'(wtre_pkg::MS_PER_S));
                elapsed_next = (elapsed == '0) ? wtre_pkg::TIME_W'(1) : elapsed;
                if (elapsed > wtre_pkg::WINDOW_MS &&
                    int'(count_reg) > wtre_pkg::WINDOW_SECONDS) begin
                    oldest_next = wtre_pkg::ring_add(oldest_reg, wtre_pkg::CNT_W'(1));
                    count_next  = count_reg - 1'b1;
                end
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    hold_next  = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            count_reg   <= wtre_pkg::CNT_W'(1);
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            count_reg   <= count_next;
            hold_reg    <= hold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        actual_reg  <= actual_next;
        num_reg     <= num_next;
        elapsed_reg <= elapsed_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(wtre_pkg::M_TDATA_W - wtre_pkg::RATE_W){1'b0}}, m_data_reg};

endmodule
